// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CDA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_date_advance: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define CDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_date_advance: next-cycle check failed");

`endif

// ===== rtl/core/cda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_ADD     = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [4:0]  RESET_DAY  = 5'd9;
    localparam logic [3:0]  RESET_MON  = 4'd9;
    localparam logic [13:0] RESET_YEAR = 14'd2000;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for any 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [13:0] load_year;
        logic [15:0] day_count;
    } in_t;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        overflow;
    } out_t;

    typedef struct packed {
        logic capture;
        logic ld_mod;
        logic ld_day;
        logic add_step;
    } cmd_t;

    typedef struct packed {
        logic add_finish;
    } stat_t;

    // ymod: year mod 100, ycent: (year / 100) mod 4, ylo: year mod 4
    function automatic logic is_leap(input logic [6:0] ymod, input logic [1:0] ycent,
                                     input logic [1:0] ylo);
        logic leap;
        if (ymod == 7'd0)
            leap = (ycent == 2'd0);
        else
            leap = (ylo == 2'd0);
        return leap;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cda_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cda_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    operation,
    input  wire cda_pkg::stat_t stat,
    output cda_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               done
);
    import cda_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LD_MOD = 3'd1;
    localparam logic [2:0] S_LD_DAY = 3'd2;
    localparam logic [2:0] S_ADD    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (operation)
                        OP_LOAD:    state_next = S_LD_MOD;
                        OP_ADVANCE: state_next = S_ADD;
                        OP_ADD:     state_next = S_ADD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_LD_MOD:
            begin
                cmd.ld_mod = 1'b1;
                state_next = S_LD_DAY;
            end
            S_LD_DAY:
            begin
                cmd.ld_day = 1'b1;
                state_next = S_DONE;
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (stat.add_finish)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/cda_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cda_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cda_pkg::in_t  request,
    input  wire cda_pkg::cmd_t cmd,
    output cda_pkg::stat_t     stat,
    output cda_pkg::out_t      result
);
    import cda_pkg::*;

    logic [4:0]  day_reg,   day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg,  year_next;
    logic [6:0]  ymod_reg,  ymod_next;
    logic [1:0]  ycent_reg, ycent_next;
    logic [16:0] total_reg, total_next;
    logic [6:0]  quo_reg,   quo_next;
    logic        ovf_reg,   ovf_next;

    logic [13:0] ld_year;
    logic [26:0] prod;
    logic        leap;
    logic [4:0]  len;
    logic [13:0] quo_x100;

    assign leap     = is_leap(ymod_reg, ycent_reg, year_reg[1:0]);
    assign len      = month_len(month_reg, leap);
    assign ld_year  = (request.load_year > YEAR_MAX) ? YEAR_MAX : request.load_year;
    assign prod     = {13'd0, ld_year} * {14'd0, DIV100_MUL};
    assign quo_x100 = {1'b0, quo_reg, 6'd0} + {2'b0, quo_reg, 5'd0} + {5'd0, quo_reg, 2'd0};

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        ycent_next = ycent_reg;
        total_next = total_reg;
        quo_next   = quo_reg;
        ovf_next   = ovf_reg;
        stat.add_finish = 1'b0;

        if (cmd.capture)
        begin
            ovf_next = 1'b0;
            case (request.operation)
                OP_LOAD:
                begin
                    if (request.load_month == 4'd0)
                        month_next = 4'd1;
                    else if (request.load_month > 4'd12)
                        month_next = 4'd12;
                    else
                        month_next = request.load_month;
                    day_next  = (request.load_day == 5'd0) ? 5'd1 : request.load_day;
                    year_next = ld_year;
                    ovf_next  = (request.load_year > YEAR_MAX);
                    quo_next  = prod[DIV100_SHIFT + 6:DIV100_SHIFT];
                end
                OP_ADVANCE:
                    total_next = {12'd0, day_reg} + 17'd1;
                OP_ADD:
                    total_next = {12'd0, day_reg} + {1'b0, request.day_count};
                default:
                    ovf_next = 1'b0;
            endcase
        end

        if (cmd.ld_mod)
        begin
            ymod_next  = 7'(year_reg - quo_x100);
            ycent_next = quo_reg[1:0];
        end

        if (cmd.ld_day)
        begin
            if (day_reg > len)
                day_next = len;
        end

        if (cmd.add_step)
        begin
            if (total_reg > {12'd0, len})
            begin
                if (month_reg >= 4'd12)
                begin
                    if (year_reg >= YEAR_MAX)
                    begin
                        day_next   = 5'd31;
                        month_next = 4'd12;
                        year_next  = YEAR_MAX;
                        ovf_next   = 1'b1;
                        stat.add_finish = 1'b1;
                    end
                    else
                    begin
                        year_next  = year_reg + 14'd1;
                        month_next = 4'd1;
                        day_next   = 5'd1;
                        total_next = total_reg - {12'd0, len};
                        if (ymod_reg == 7'd99)
                        begin
                            ymod_next  = 7'd0;
                            ycent_next = ycent_reg + 2'd1;
                        end
                        else
                            ymod_next = ymod_reg + 7'd1;
                    end
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                    day_next   = 5'd1;
                    total_next = total_reg - {12'd0, len};
                end
            end
            else
            begin
                day_next = total_reg[4:0];
                stat.add_finish = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= RESET_DAY;
            month_reg <= RESET_MON;
            year_reg  <= RESET_YEAR;
            ymod_reg  <= 7'd0;
            ycent_reg <= 2'd0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            ymod_reg  <= ymod_next;
            ycent_reg <= ycent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        quo_reg   <= quo_next;
        ovf_reg   <= ovf_next;
    end

    assign result.out_day   = day_reg;
    assign result.out_month = month_reg;
    assign result.out_year  = year_reg;
    assign result.overflow  = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/core/calendar_date_advance.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Channel   Ports              Transfer
// request   start / busy       start high, busy low at the clock edge
// result    done / result      done high for one cycle, always taken
//
// Steps after accept: load passes S_LD_MOD and S_LD_DAY, a no-op goes straight
// to S_DONE, and advance and add run the S_ADD loop (one month per cycle) until
// the day lands within a month or the year saturates, then pass S_DONE.
// busy stays high from the accept edge through the strobe cycle.
// Reset (rst_n low, asynchronous) sets the date to 9/9/2000 and goes idle.
// The result side cannot stall; each result is strobed by done for one cycle only.

module calendar_date_advance (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire cda_pkg::in_t request,
    output logic              busy,
    output logic              done,
    output cda_pkg::out_t     result
);
    import cda_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  date_ok;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    cda_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    assign date_ok = (result.out_day != 5'd0) && (result.out_month != 4'd0) &&
                     (result.out_month <= 4'd12) && (result.out_year <= YEAR_MAX);

    `CDA_ASSERT_SAME(a_done_busy, done, busy)
    `CDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `CDA_ASSERT_SAME(a_date_valid, done, date_ok)
    `CDA_ASSERT_SAME(a_ovf_year, done && result.overflow, result.out_year == YEAR_MAX)

endmodule

`default_nettype wire
